// File: design/csvseg_pkg.sv
// csvseg_pkg: shared types, constants and register indexes of the CSV row segmenter.
// Used by csv_row_segmenter, csvseg_cfg and csvseg_step; no dependencies.
`default_nettype none

package csvseg_pkg;

    // counter width default for the row and byte counters
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int ROWS_OUT_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ROWS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONE_CR   = 2'd3;

    // register reset values
    localparam logic [31:0] MIN_BYTES_RST = 32'd10485760;
    localparam logic [15:0] MIN_ROWS_RST  = 16'd3;
    localparam logic [31:0] MAX_ROWS_RST  = 32'd0;
    localparam logic        LONE_CR_RST   = 1'b0;

    // special characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [5:0] {
        MODE_PLAIN      = 6'b000001,
        MODE_QUOTED     = 6'b000010,
        MODE_QUOTE_SEEN = 6'b000100,
        MODE_AFTER_LF   = 6'b001000,
        MODE_AFTER_CR   = 6'b010000,
        MODE_CLOSED     = 6'b100000
    } t_mode;

    typedef struct packed {
        logic [31:0] need_bytes;
        logic [15:0] need_rows;
        logic [31:0] row_cap;
        logic        lone_cr;
    } t_cfg;

    typedef struct packed {
        logic                  taken;
        logic                  row_closed;
        logic [ROWS_OUT_W-1:0] rows;
        logic                  done;
        logic                  quotes;
    } t_result;

endpackage

`default_nettype wire

// File: design/csv_row_segmenter.sv
// csv_row_segmenter: top level of the CSV row segmenter.
// Depends on csvseg_pkg, csvseg_cfg and csvseg_step.
//
// Usage:
//   Input stream: one CSV byte per transfer on i_s_tdata[7:0]; i_s_tlast marks the last
//   byte of the whole text. Output stream: one result per input byte. o_m_tdata carries
//   the row count of the current segment, o_m_tuser the flags taken, row_closed and
//   inside_quotes, o_m_tlast the segment-close flag.
//   Configuration: write i_cfg_wdata to register i_cfg_index while i_cfg_we is high;
//   index 0 min segment bytes, 1 min segment rows, 2 max segment rows, 3 lone CR ends row.
//   Write only while no byte is in flight.
//   Datapath: the result of a byte is computed from the input register and presented
//   from the result register; an output stall can hold the byte in the input register.
//   Throughput: one byte per cycle while i_m_tready is high; the scanner state is updated
//   by combinational logic in the step from input register to result register.
//   Reset: synchronous, active low; clears both stages, the scan state and the counters
//   and loads the register defaults. After the last byte of a text the scan state and
//   counters return to their reset values; the registers keep theirs.
//   Stall: when i_m_tready is low the result holds, the input register fills, and then
//   o_s_tready drops; no byte is lost or repeated.
`default_nettype none

module csv_row_segmenter #(
    parameter int COUNT_WIDTH = csvseg_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input stream
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [7:0]                       i_s_tdata,  // [7:0] data_byte
    input  wire logic                             i_s_tlast,  // end_of_input
    // output stream
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [31:0]                           o_m_tdata,  // [31:0] rows_in_segment
    output logic [2:0]                            o_m_tuser,  // [0] taken, [1] row_closed,
                                                              // [2] inside_quotes
    output logic                                  o_m_tlast,  // segment_done
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [csvseg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [csvseg_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    csvseg_pkg::t_cfg        cfg;
    csvseg_pkg::t_mode       r_mode, n_mode;
    logic [COUNT_WIDTH-1:0] r_rows, n_rows;
    logic [COUNT_WIDTH-1:0] r_bytes, n_bytes;
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_last;
    logic                   r_out_valid;
    csvseg_pkg::t_result     r_out, n_out;
    logic                   advance;
    logic                   in_xfer;

    csvseg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    csvseg_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_mode  (r_mode),
        .i_rows  (r_rows),
        .i_bytes (r_bytes),
        .i_byte  (r_in_byte),
        .i_eoi   (r_in_last),
        .i_cfg   (cfg),
        .o_mode  (n_mode),
        .o_rows  (n_rows),
        .o_bytes (n_bytes),
        .o_res   (n_out)
    );

    // the buffered byte moves on when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_xfer    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= csvseg_pkg::MODE_PLAIN;
            r_rows      <= '0;
            r_bytes     <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_rows      <= n_rows;
                r_bytes     <= n_bytes;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.rows;
    assign o_m_tuser  = {r_out.quotes, r_out.row_closed, r_out.taken};
    assign o_m_tlast  = r_out.done;

endmodule

`default_nettype wire

// File: design/csvseg_cfg.sv
// csvseg_cfg: configuration register file of the CSV row segmenter.
// Depends on csvseg_pkg for register indexes, reset values and the t_cfg struct.
`default_nettype none

module csvseg_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [csvseg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [csvseg_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output csvseg_pkg::t_cfg                      o_cfg
);

    csvseg_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.need_bytes <= csvseg_pkg::MIN_BYTES_RST;
            r_cfg.need_rows  <= csvseg_pkg::MIN_ROWS_RST;
            r_cfg.row_cap    <= csvseg_pkg::MAX_ROWS_RST;
            r_cfg.lone_cr    <= csvseg_pkg::LONE_CR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                csvseg_pkg::REG_MIN_BYTES: r_cfg.need_bytes <= i_cfg_wdata[31:0];
                csvseg_pkg::REG_MIN_ROWS:  r_cfg.need_rows  <= i_cfg_wdata[15:0];
                csvseg_pkg::REG_MAX_ROWS:  r_cfg.row_cap    <= i_cfg_wdata[31:0];
                csvseg_pkg::REG_LONE_CR:   r_cfg.lone_cr    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: design/csvseg_step.sv
// csvseg_step: next-state and result logic for one byte of the CSV row segmenter.
// Pure combinational; depends on csvseg_pkg for modes, characters and structs.
`default_nettype none

module csvseg_step #(
    parameter int COUNT_WIDTH = csvseg_pkg::COUNT_WIDTH_DEF
) (
    input  wire csvseg_pkg::t_mode     i_mode,
    input  wire logic [COUNT_WIDTH-1:0] i_rows,
    input  wire logic [COUNT_WIDTH-1:0] i_bytes,
    input  wire logic [7:0]             i_byte,
    input  wire logic                   i_eoi,
    input  wire csvseg_pkg::t_cfg      i_cfg,
    output csvseg_pkg::t_mode          o_mode,
    output logic [COUNT_WIDTH-1:0]      o_rows,
    output logic [COUNT_WIDTH-1:0]      o_bytes,
    output csvseg_pkg::t_result        o_res
);

    localparam int WIDE = (COUNT_WIDTH > csvseg_pkg::ROWS_OUT_W) ?
                          COUNT_WIDTH : csvseg_pkg::ROWS_OUT_W;
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    function automatic logic close_test(
        input logic [COUNT_WIDTH-1:0] rc,
        input logic [COUNT_WIDTH-1:0] bc,
        input csvseg_pkg::t_cfg       cfg,
        input logic [31:0]            lim
    );
        logic [WIDE-1:0] rcw;
        logic [WIDE-1:0] bcw;
        rcw = WIDE'(rc);
        bcw = WIDE'(bc);
        return (rcw >= WIDE'(cfg.need_rows)) &&
               ((bcw >= WIDE'(cfg.need_bytes)) || ((lim != 32'd0) && (rcw == WIDE'(lim))));
    endfunction

    csvseg_pkg::t_mode       m0;
    csvseg_pkg::t_mode       m;
    logic [COUNT_WIDTH-1:0] rc0, bc0, rc_p1, rc_p2, bc_p1;
    logic [COUNT_WIDTH-1:0] rc1, bc1, rc2, bc2, rc_fin, bc_fin, rep;
    logic [WIDE-1:0]        repw;
    logic [31:0]            lim;
    logic                   cons_a, ends_a, close_a, ends_b, close_b;
    logic                   consumed, fresh, taken, row_b;
    logic                   is_quote, is_lf, is_cr;

    assign is_quote = (i_byte == csvseg_pkg::CH_QUOTE);
    assign is_lf    = (i_byte == csvseg_pkg::CH_LF);
    assign is_cr    = (i_byte == csvseg_pkg::CH_CR);

    // effective row limit: nonzero values below the minimum are raised to it
    assign lim = ((i_cfg.row_cap != 32'd0) && (i_cfg.row_cap < {16'd0, i_cfg.need_rows})) ?
                 {16'd0, i_cfg.need_rows} : i_cfg.row_cap;

    // a closed segment starts over with cleared counters
    assign rc0 = (i_mode == csvseg_pkg::MODE_CLOSED) ? '0 : i_rows;
    assign bc0 = (i_mode == csvseg_pkg::MODE_CLOSED) ? '0 : i_bytes;

    assign rc_p1 = (rc0 == CMAX) ? CMAX : rc0 + COUNT_WIDTH'(1);
    assign rc_p2 = (rc0 >= CMAX - COUNT_WIDTH'(1)) ? CMAX : rc0 + COUNT_WIDTH'(2);
    assign bc_p1 = (bc0 == CMAX) ? CMAX : bc0 + COUNT_WIDTH'(1);

    always_comb begin
        case (i_mode)
            csvseg_pkg::MODE_PLAIN,
            csvseg_pkg::MODE_QUOTED,
            csvseg_pkg::MODE_QUOTE_SEEN,
            csvseg_pkg::MODE_AFTER_LF,
            csvseg_pkg::MODE_AFTER_CR: m0 = i_mode;
            default:                   m0 = csvseg_pkg::MODE_PLAIN;
        endcase
    end

    always_comb begin
        m        = m0;
        cons_a   = 1'b0;
        ends_a   = 1'b0;
        close_a  = 1'b0;
        consumed = 1'b0;
        fresh    = 1'b0;
        taken    = 1'b1;
        rc1      = rc0;
        bc1      = bc0;

        // first pass: pending line end or quote state
        case (m0)
            csvseg_pkg::MODE_AFTER_LF,
            csvseg_pkg::MODE_AFTER_CR: begin
                cons_a = ((m0 == csvseg_pkg::MODE_AFTER_LF) && is_cr) ||
                         ((m0 == csvseg_pkg::MODE_AFTER_CR) && is_lf);
                ends_a = cons_a || (m0 == csvseg_pkg::MODE_AFTER_LF) || i_cfg.lone_cr;
                consumed = cons_a;
                bc1 = cons_a ? bc_p1 : bc0;
                m = csvseg_pkg::MODE_PLAIN;
                if (ends_a) begin
                    rc1 = rc_p1;
                    close_a = close_test(rc_p1, bc1, i_cfg, lim);
                end
                if (close_a) begin
                    if (cons_a) begin
                        m = csvseg_pkg::MODE_CLOSED;
                    end else begin
                        // this byte opens the next segment
                        fresh = 1'b1;
                        taken = 1'b0;
                    end
                end
            end
            csvseg_pkg::MODE_QUOTE_SEEN: begin
                if (is_quote) begin
                    consumed = 1'b1;
                    bc1 = bc_p1;
                    m = csvseg_pkg::MODE_QUOTED;
                end else begin
                    m = csvseg_pkg::MODE_PLAIN;
                end
            end
            csvseg_pkg::MODE_QUOTED: begin
                consumed = 1'b1;
                bc1 = bc_p1;
                if (is_quote) begin
                    m = csvseg_pkg::MODE_QUOTE_SEEN;
                end
            end
            default: ;
        endcase

        // second pass: byte scanned as plain text
        ends_b  = 1'b0;
        close_b = 1'b0;
        row_b   = 1'b0;
        rc2     = ends_a ? rc_p2 : rc_p1;
        bc2     = fresh ? COUNT_WIDTH'(1) : bc_p1;
        rc_fin  = rc1;
        bc_fin  = bc1;
        if (!consumed) begin
            bc_fin = bc2;
            rc_fin = fresh ? '0 : rc1;
            if (is_quote) begin
                m = csvseg_pkg::MODE_QUOTED;
            end else if (is_lf) begin
                if (i_eoi) begin
                    ends_b = 1'b1;
                end else begin
                    m = csvseg_pkg::MODE_AFTER_LF;
                end
            end else if (is_cr) begin
                if (i_eoi) begin
                    ends_b = i_cfg.lone_cr;
                end else begin
                    m = csvseg_pkg::MODE_AFTER_CR;
                end
            end
            if (ends_b && !fresh) begin
                row_b   = 1'b1;
                rc_fin  = rc2;
                close_b = close_test(rc2, bc2, i_cfg, lim);
                if (close_b) begin
                    m = csvseg_pkg::MODE_CLOSED;
                end
            end
        end

        // a quote on the last byte closes the quoted field
        if (i_eoi && (m == csvseg_pkg::MODE_QUOTE_SEEN)) begin
            m = csvseg_pkg::MODE_PLAIN;
        end

        rep  = fresh ? rc1 : rc_fin;
        repw = WIDE'(rep);

        o_res.taken      = taken;
        o_res.row_closed = ends_a || row_b;
        o_res.rows       = (repw > WIDE'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : repw[31:0];
        o_res.done       = close_a || close_b;
        o_res.quotes     = (m == csvseg_pkg::MODE_QUOTED) || (m == csvseg_pkg::MODE_QUOTE_SEEN);

        if (i_eoi) begin
            o_mode  = csvseg_pkg::MODE_PLAIN;
            o_rows  = '0;
            o_bytes = '0;
        end else begin
            o_mode  = m;
            o_rows  = rc_fin;
            o_bytes = bc_fin;
        end
    end

endmodule

`default_nettype wire

// File: design/csvseg_chk.sv
// csvseg_chk: port-level assertion checker for csv_row_segmenter, with its bind.
// Sees only the top-level handshake and result ports; no package dependency.
`default_nettype none

module csvseg_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata,
    input wire logic [2:0]  o_m_tuser,
    input wire logic        o_m_tlast
);

    // nothing comes out in the cycle after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // a segment closes only when a row is counted
    a_close_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser[1])
        else $error("segment closed without a row end");

    // a byte that opens the next segment comes with the close of the previous one
    a_untaken_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tlast)
        else $error("byte not taken without segment close");

    // the input side is ready whenever the result side drains
    a_ready_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> o_s_tready)
        else $error("input not ready while output drains");

endmodule

bind csv_row_segmenter csvseg_chk u_csvseg_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser),
    .o_m_tlast   (o_m_tlast)
);

`default_nettype wire
